@@ rtl/lca_pkg.sv @@
`timescale 1ns / 1ps

package lca_pkg;

	// default grid bounds
	localparam int DEF_MAX_COLS = 64;
	localparam int DEF_MAX_ROWS = 64;

	// neighbour counts 0..8, one mask bit each
	localparam int NBR_COUNT = 9;

	localparam int CFG_W   = 9;
	localparam int SIZE_W  = 7;
	localparam int COORD_W = 6;
	localparam int CNT_W   = 16;
	localparam int GEN_W   = 32;

	localparam logic [CFG_W-1:0]  BIRTH_RESET   = 9'd8;
	localparam logic [CFG_W-1:0]  SURVIVE_RESET = 9'd12;
	localparam logic [SIZE_W-1:0] SIZE_RESET    = 7'd64;

	// register indexes
	localparam logic [1:0] REG_BIRTH   = 2'd0;
	localparam logic [1:0] REG_SURVIVE = 2'd1;
	localparam logic [1:0] REG_COLS    = 2'd2;
	localparam logic [1:0] REG_ROWS    = 2'd3;

	typedef enum logic [1:0] {
		OP_WRITE   = 2'd0,
		OP_ADVANCE = 2'd1,
		OP_READ    = 2'd2,
		OP_NONE    = 2'd3
	} op_t;

	typedef struct packed {
		op_t                op;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic               cell_in;
		logic [CNT_W-1:0]   gen_count;
	} in_word_t;

	typedef struct packed {
		logic             cell_out;
		logic [GEN_W-1:0] generation;
	} out_word_t;

	// grid store control from the sequencer
	typedef struct packed {
		logic bank_sel;
		logic wr_en;
		logic wr_other;
	} store_ctl_t;

endpackage

@@ rtl/lca_ram.sv @@
`timescale 1ns / 1ps

module lca_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ rtl/lca_grid_store.sv @@
`timescale 1ns / 1ps

module lca_grid_store #(
	parameter int ROWS = lca_pkg::DEF_MAX_ROWS,
	parameter int COLS = lca_pkg::DEF_MAX_COLS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  lca_pkg::store_ctl_t     ctl,
	input  logic [$clog2(ROWS)-1:0] a_addr,
	output logic [COLS-1:0]         a_data,
	input  logic [$clog2(ROWS)-1:0] b_addr,
	output logic [COLS-1:0]         b_data,
	input  logic [$clog2(ROWS)-1:0] wr_addr,
	input  logic [COLS-1:0]         wr_data
);

	localparam int RW = $clog2(ROWS);

	logic [RW-1:0]   raddr0, raddr1;
	logic [COLS-1:0] q0, q1;
	logic            target, we0, we1;
	logic            bank_s1;

	// port a follows the current bank, port b the other one
	assign raddr0 = ctl.bank_sel ? b_addr : a_addr;
	assign raddr1 = ctl.bank_sel ? a_addr : b_addr;
	assign target = ctl.bank_sel ^ ctl.wr_other;
	assign we0    = ctl.wr_en & ~target;
	assign we1    = ctl.wr_en & target;

	lca_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_bank0 (
		.clk   (clk),
		.we    (we0),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (raddr0),
		.rdata (q0)
	);

	lca_ram #(.WIDTH(COLS), .DEPTH(ROWS)) u_bank1 (
		.clk   (clk),
		.we    (we1),
		.waddr (wr_addr),
		.wdata (wr_data),
		.raddr (raddr1),
		.rdata (q1)
	);

	// bank select of the read in flight
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_s1 <= 1'b0;
		end else begin
			bank_s1 <= ctl.bank_sel;
		end
	end

	assign a_data = bank_s1 ? q1 : q0;
	assign b_data = bank_s1 ? q0 : q1;

endmodule

@@ rtl/lca_row_engine.sv @@
`timescale 1ns / 1ps

module lca_row_engine #(
	parameter int COLS = lca_pkg::DEF_MAX_COLS
) (
	input  logic [COLS-1:0]              prev_row,
	input  logic [COLS-1:0]              cur_row,
	input  logic [COLS-1:0]              next_row,
	input  logic [COLS-1:0]              cur_raw,
	input  logic [COLS-1:0]              col_mask,
	input  logic                         row_act,
	input  logic [lca_pkg::NBR_COUNT-1:0] birth,
	input  logic [lca_pkg::NBR_COUNT-1:0] survive,
	output logic [COLS-1:0]              new_row
);

	// one lane per column; neighbour rows come in already masked to the area
	for (genvar c = 0; c < COLS; c++) begin : g_lane
		logic       l_p, l_c, l_n, r_p, r_c, r_n;
		logic [3:0] n;

		if (c == 0) begin : g_left_edge
			assign {l_p, l_c, l_n} = 3'b000;
		end else begin : g_left
			assign {l_p, l_c, l_n} = {prev_row[c-1], cur_row[c-1], next_row[c-1]};
		end

		if (c == COLS - 1) begin : g_right_edge
			assign {r_p, r_c, r_n} = 3'b000;
		end else begin : g_right
			assign {r_p, r_c, r_n} = {prev_row[c+1], cur_row[c+1], next_row[c+1]};
		end

		assign n = 4'(l_p) + 4'(l_c) + 4'(l_n) + 4'(prev_row[c]) + 4'(next_row[c])
			+ 4'(r_p) + 4'(r_c) + 4'(r_n);

		// cells outside the area keep their stored value
		assign new_row[c] = (row_act && col_mask[c]) ?
			(cur_raw[c] ? survive[n] : birth[n]) : cur_raw[c];
	end

endmodule

@@ rtl/life_like_cellular_automaton.sv @@
// Life-like cellular automaton with a configurable birth/survive rule. The grid is
// MAX_ROWS x MAX_COLS one-bit cells held as rows in two banks of synchronous RAM
// (one row per word); the active area is grid_rows x grid_cols and everything
// outside it counts as dead. Each input word either writes a cell, reads a cell,
// or advances the grid by gen_count generations, and gives exactly one result
// word carrying the read cell and the running 32-bit generation count. A cell
// write or read inside the area raises out_valid after the row read, then the modify
// or select, then the result register; one outside the area, an unused op or a
// zero-generation advance goes straight to the result register. An advance sweeps
// the grid once per generation: a sweep streams the current bank row by row
// through a three-row window and writes each new row into the other bank, so the
// single read port per bank sets the pace. A sweep ends the advance early when the
// grid stops changing or starts to alternate with period two, so a settled pattern
// costs at most two sweeps however large gen_count is. After reset the block writes
// every row of bank 0 dead, with in_stall high; configuration writes are taken at
// any time but must only be issued while the block is idle.
`timescale 1ns / 1ps

module life_like_cellular_automaton #(
	parameter int MAX_COLS = lca_pkg::DEF_MAX_COLS,
	parameter int MAX_ROWS = lca_pkg::DEF_MAX_ROWS
) (
	input  logic                        clk,
	input  logic                        arst_n,
	// command words
	input  logic                        in_valid,
	output logic                        in_stall,
	input  lca_pkg::in_word_t           in_data,
	// result words
	output logic                        out_valid,
	input  logic                        out_stall,
	output lca_pkg::out_word_t          out_data,
	// configuration
	input  logic                        cfg_we,
	input  logic [1:0]                  cfg_index,
	input  logic [lca_pkg::CFG_W-1:0]   cfg_wdata
);

	localparam int RW    = $clog2(MAX_ROWS);
	localparam int CIW   = $clog2(MAX_COLS);
	localparam int KW    = $clog2(MAX_ROWS + 2);
	localparam int SZC_W = ($clog2(MAX_COLS + 1) > lca_pkg::SIZE_W) ?
		$clog2(MAX_COLS + 1) : lca_pkg::SIZE_W;
	localparam int SZR_W = (KW > lca_pkg::SIZE_W) ? KW : lca_pkg::SIZE_W;

	typedef enum logic [4:0] {
		ST_CLEAR  = 5'b00001,
		ST_IDLE   = 5'b00010,
		ST_READ   = 5'b00100,
		ST_SWEEP  = 5'b01000,
		ST_FINISH = 5'b10000
	} state_t;

	state_t state_q;

	// configuration
	logic [lca_pkg::CFG_W-1:0]  birth_q, survive_q;
	logic [lca_pkg::SIZE_W-1:0] cols_cfg_q, rows_cfg_q;
	logic [SZC_W-1:0]           cols_ext, cols_eff;
	logic [SZR_W-1:0]           rows_ext, rows_eff;
	logic [MAX_COLS-1:0]        col_mask;

	// item being worked on
	lca_pkg::op_t              op_q;
	logic [CIW-1:0]            col_q;
	logic [RW-1:0]             row_q;
	logic                      cell_q;
	logic [lca_pkg::CNT_W-1:0] cnt_q, gen_idx_q, gen_nxt;
	logic                      res_cell_q;
	logic [lca_pkg::GEN_W-1:0] gen_q;
	logic                      bank_sel_q;
	logic                      in_acc, in_area;

	// clearing pass after reset
	logic [RW-1:0]       clr_q;

	// sweep
	logic [KW-1:0]       k_q, km1, row_s1, jm1;
	logic                vld_s1, issue, sweep_end, row_compute;
	logic [MAX_COLS-1:0] cur_q, prev_nb_q, cur_nb, next_nb, new_row;
	logic                cur_act_q, next_act;
	logic                chg_q, dif_q, chg_all, dif_all;

	// store port
	lca_pkg::store_ctl_t st_ctl;
	logic [RW-1:0]       a_addr, b_addr, wr_addr;
	logic [MAX_COLS-1:0] a_data, b_data, wr_data, rmw_row;

	lca_pkg::out_word_t out_data_q;
	logic               out_valid_q, out_load;

	// ---------------------------------------------------------------- config
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			birth_q    <= lca_pkg::BIRTH_RESET;
			survive_q  <= lca_pkg::SURVIVE_RESET;
			cols_cfg_q <= lca_pkg::SIZE_RESET;
			rows_cfg_q <= lca_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				lca_pkg::REG_BIRTH:   birth_q    <= cfg_wdata;
				lca_pkg::REG_SURVIVE: survive_q  <= cfg_wdata;
				lca_pkg::REG_COLS:    cols_cfg_q <= cfg_wdata[lca_pkg::SIZE_W-1:0];
				lca_pkg::REG_ROWS:    rows_cfg_q <= cfg_wdata[lca_pkg::SIZE_W-1:0];
			endcase
		end
	end

	// zero acts as one, oversize acts as the maximum
	assign cols_ext = SZC_W'(cols_cfg_q);
	assign rows_ext = SZR_W'(rows_cfg_q);

	always_comb begin
		if (cols_ext == '0) begin
			cols_eff = SZC_W'(1);
		end else if (cols_ext > SZC_W'(MAX_COLS)) begin
			cols_eff = SZC_W'(MAX_COLS);
		end else begin
			cols_eff = cols_ext;
		end
		if (rows_ext == '0) begin
			rows_eff = SZR_W'(1);
		end else if (rows_ext > SZR_W'(MAX_ROWS)) begin
			rows_eff = SZR_W'(MAX_ROWS);
		end else begin
			rows_eff = rows_ext;
		end
	end

	always_comb begin
		for (int c = 0; c < MAX_COLS; c++) begin
			col_mask[c] = SZC_W'(c) < cols_eff;
		end
	end

	// ---------------------------------------------------------------- handshake
	assign in_stall = (state_q != ST_IDLE);
	assign in_acc   = in_valid && !in_stall;
	assign in_area  = (SZC_W'(in_data.col) < cols_eff) && (SZR_W'(in_data.row) < rows_eff);
	assign out_load = (state_q == ST_FINISH) && (!out_valid_q || !out_stall);

	// ---------------------------------------------------------------- sweep datapath
	// issue row k of the current bank and old row k-1 of the other bank;
	// in the next cycle row j = k arrives and row j-1 is computed and written
	assign issue       = (k_q <= KW'(MAX_ROWS));
	assign km1         = k_q - KW'(1);
	assign jm1         = row_s1 - KW'(1);
	assign row_compute = (state_q == ST_SWEEP) && vld_s1 && (row_s1 != '0);
	assign sweep_end   = (state_q == ST_SWEEP) && vld_s1 && (row_s1 == KW'(MAX_ROWS));
	assign next_act    = SZR_W'(row_s1) < rows_eff;
	assign next_nb     = next_act ? (a_data & col_mask) : '0;
	assign cur_nb      = cur_act_q ? (cur_q & col_mask) : '0;
	assign chg_all     = chg_q | (|(new_row ^ cur_q));
	assign dif_all     = dif_q | (|(new_row ^ b_data));
	assign gen_nxt     = gen_idx_q + 16'd1;

	lca_row_engine #(.COLS(MAX_COLS)) u_engine (
		.prev_row (prev_nb_q),
		.cur_row  (cur_nb),
		.next_row (next_nb),
		.cur_raw  (cur_q),
		.col_mask (col_mask),
		.row_act  (cur_act_q),
		.birth    (birth_q),
		.survive  (survive_q),
		.new_row  (new_row)
	);

	// single-cell write merges into the fetched row
	always_comb begin
		rmw_row        = a_data;
		rmw_row[col_q] = cell_q;
	end

	always_comb begin
		st_ctl.bank_sel = bank_sel_q;
		st_ctl.wr_en    = 1'b0;
		st_ctl.wr_other = 1'b0;
		wr_addr         = row_q;
		wr_data         = rmw_row;
		a_addr          = (state_q == ST_SWEEP) ? k_q[RW-1:0] : RW'(in_data.row);
		b_addr          = km1[RW-1:0];
		if (state_q == ST_CLEAR) begin
			// bank select is still zero here, so this lands in bank 0
			st_ctl.wr_en = 1'b1;
			wr_addr      = clr_q;
			wr_data      = '0;
		end else if (state_q == ST_READ && op_q == lca_pkg::OP_WRITE) begin
			st_ctl.wr_en = 1'b1;
		end else if (row_compute) begin
			st_ctl.wr_en    = 1'b1;
			st_ctl.wr_other = 1'b1;
			wr_addr         = jm1[RW-1:0];
			wr_data         = new_row;
		end
	end

	lca_grid_store #(.ROWS(MAX_ROWS), .COLS(MAX_COLS)) u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (st_ctl),
		.a_addr  (a_addr),
		.a_data  (a_data),
		.b_addr  (b_addr),
		.b_data  (b_data),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	// ---------------------------------------------------------------- sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_CLEAR;
			clr_q       <= '0;
			bank_sel_q  <= 1'b0;
			gen_q       <= '0;
			k_q         <= '0;
			vld_s1      <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= out_load || (out_valid_q && out_stall);
			unique case (state_q)
				ST_CLEAR: begin
					// one dead row per cycle
					clr_q <= clr_q + RW'(1);
					if (clr_q == RW'(MAX_ROWS - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (in_acc) begin
						unique case (in_data.op)
							lca_pkg::OP_WRITE, lca_pkg::OP_READ: begin
								state_q <= in_area ? ST_READ : ST_FINISH;
							end
							lca_pkg::OP_ADVANCE: begin
								state_q <= (in_data.gen_count != '0) ? ST_SWEEP : ST_FINISH;
								k_q     <= '0;
							end
							lca_pkg::OP_NONE: begin
								state_q <= ST_FINISH;
							end
						endcase
					end
				end
				ST_READ: begin
					state_q <= ST_FINISH;
				end
				ST_SWEEP: begin
					vld_s1 <= issue;
					if (issue) begin
						k_q <= k_q + KW'(1);
					end
					if (sweep_end) begin
						if (!chg_all) begin
							// fixed point
							state_q <= ST_FINISH;
							gen_q   <= gen_q + 32'(cnt_q);
						end else if (gen_idx_q != '0 && !dif_all) begin
							// period two: land on the bank that matches the final parity
							state_q    <= ST_FINISH;
							gen_q      <= gen_q + 32'(cnt_q);
							bank_sel_q <= bank_sel_q ^ (cnt_q[0] ^ gen_idx_q[0]);
						end else begin
							bank_sel_q <= ~bank_sel_q;
							if (gen_nxt == cnt_q) begin
								state_q <= ST_FINISH;
								gen_q   <= gen_q + 32'(cnt_q);
							end else begin
								k_q <= '0;
							end
						end
					end
				end
				ST_FINISH: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// item fields, read result, window rows, sweep flags and the output word
	always_ff @(posedge clk) begin
		if (in_acc) begin
			op_q       <= in_data.op;
			col_q      <= CIW'(in_data.col);
			row_q      <= RW'(in_data.row);
			cell_q     <= in_data.cell_in;
			cnt_q      <= in_data.gen_count;
			gen_idx_q  <= '0;
			res_cell_q <= 1'b0;
		end
		if (state_q == ST_READ && op_q == lca_pkg::OP_READ) begin
			res_cell_q <= a_data[col_q];
		end
		if (sweep_end && chg_all && !(gen_idx_q != '0 && !dif_all)) begin
			gen_idx_q <= gen_nxt;
		end
		if (state_q == ST_SWEEP && vld_s1) begin
			cur_q     <= a_data;
			cur_act_q <= next_act;
			if (row_s1 == '0) begin
				prev_nb_q <= '0;
				chg_q     <= 1'b0;
				dif_q     <= 1'b0;
			end else begin
				prev_nb_q <= cur_nb;
				chg_q     <= chg_all;
				dif_q     <= dif_all;
			end
		end
		if (state_q == ST_SWEEP) begin
			row_s1 <= k_q;
		end
		if (out_load) begin
			out_data_q.cell_out   <= res_cell_q;
			out_data_q.generation <= gen_q;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// ---------------------------------------------------------------- checks
	a_sweep_rw_apart: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP && st_ctl.wr_en) |-> (wr_addr != b_addr))
		else $error("sweep writes the row being fetched as history");

	a_gen_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SWEEP) |-> (gen_idx_q < cnt_q))
		else $error("generation index ran past the requested count");

	a_bank_flip_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(bank_sel_q != $past(bank_sel_q)) |-> ($past(state_q) == ST_SWEEP))
		else $error("bank select changed outside a sweep");

	a_gen_update: assert property (@(posedge clk) disable iff (!arst_n)
		(gen_q != $past(gen_q)) |-> ($past(state_q) == ST_SWEEP && state_q == ST_FINISH))
		else $error("generation count changed outside the end of an advance");

endmodule
